### rtl/u8d_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the UTF-8 stream decoder.
// Used by every module of the decoder; depends on nothing else.
package u8d_pkg;

	localparam int CP_W        = 21;
	localparam int TOTAL_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 1;
	localparam int EVQ_DEPTH   = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_INVALID_AS_NULL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_LEADING_BOM = 2'd1;

	localparam logic [CP_W-1:0] REPL_CP     = 21'h00FFFD;
	localparam logic [CP_W-1:0] BOM_CP      = 21'h00FEFF;
	localparam logic [CP_W-1:0] MAX_CP      = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
	localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
	localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

	// Lead byte class limits.
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;

	// Results caused by one accepted byte: one or two, in order.
	typedef struct packed {
		logic [CP_W-1:0] cp0;
		logic            bad0;
		logic [CP_W-1:0] cp1;
		logic            bad1;
		logic            two;
	} u8d_event_t;

endpackage

### rtl/u8d_front.sv
`timescale 1ns / 1ps
// Front end of the UTF-8 decoder: classifies each byte, keeps the open
// sequence and builds the one or two results it causes. Uses u8d_pkg.
module u8d_front
	import u8d_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       byte_value,
	input  logic             flush,
	input  logic             invalid_as_null,
	input  logic             drop_leading_bom,
	output logic             ev_valid,
	output u8d_event_t       ev
);

	logic [1:0]      pending_q;
	logic [1:0]      seq_len_q;
	logic [CP_W-1:0] partial_q;
	logic            header_seen_q;

	logic [1:0]      pend_n;
	logic [1:0]      len_n;
	logic [CP_W-1:0] part_n;
	logic            hdr_n;
	logic [CP_W-1:0] inv_cp;
	logic            is_cont;
	logic            broken;
	logic            do_complete;
	logic [CP_W-1:0] cv;
	logic [1:0]      ce;
	logic            comp_bad;
	logic            main_v;
	logic [CP_W-1:0] main_cp;
	logic            main_bad;
	logic            tail;
	logic [1:0]      n_res;

	always_comb begin
		inv_cp      = invalid_as_null ? '0 : REPL_CP;
		is_cont     = (byte_value[7:6] == 2'b10);
		broken      = (pending_q != 2'd0) && !is_cont;
		pend_n      = broken ? 2'd0 : pending_q;
		len_n       = broken ? 2'd0 : seq_len_q;
		part_n      = broken ? '0 : partial_q;
		hdr_n       = header_seen_q;
		do_complete = 1'b0;
		cv          = '0;
		ce          = 2'd0;
		comp_bad    = 1'b0;
		main_v      = 1'b0;
		main_cp     = '0;
		main_bad    = 1'b0;

		if (!byte_value[7]) begin
			do_complete = 1'b1;
			cv          = {{(CP_W-8){1'b0}}, byte_value};
		end else if (is_cont) begin
			if (pend_n == 2'd0) begin
				// Stray continuation with no sequence open.
				main_v   = 1'b1;
				main_cp  = inv_cp;
				main_bad = 1'b1;
			end else begin
				part_n = {part_n[CP_W-7:0], byte_value[5:0]};
				pend_n = pend_n - 2'd1;
				if (pend_n == 2'd0) begin
					do_complete = 1'b1;
					cv          = part_n;
					ce          = len_n;
					part_n      = '0;
					len_n       = 2'd0;
				end
			end
		end else if (byte_value <= LEAD2_MAX) begin
			part_n = {{(CP_W-5){1'b0}}, byte_value[4:0]};
			pend_n = 2'd1;
			len_n  = 2'd1;
		end else if (byte_value <= LEAD3_MAX) begin
			part_n = {{(CP_W-4){1'b0}}, byte_value[3:0]};
			pend_n = 2'd2;
			len_n  = 2'd2;
		end else if (byte_value <= LEAD4_MAX) begin
			part_n = {{(CP_W-3){1'b0}}, byte_value[2:0]};
			pend_n = 2'd3;
			len_n  = 2'd3;
		end else begin
			part_n   = '0;
			pend_n   = 2'd0;
			len_n    = 2'd0;
			main_v   = 1'b1;
			main_cp  = inv_cp;
			main_bad = 1'b1;
		end

		if (do_complete) begin
			hdr_n    = 1'b1;
			comp_bad = ((ce == 2'd1) && (cv < MIN_2BYTE)) ||
			           ((ce == 2'd2) && (cv < MIN_3BYTE)) ||
			           ((ce == 2'd3) && (cv < MIN_4BYTE)) ||
			           ((cv >= SURR_LO) && (cv <= SURR_HI)) ||
			           (cv > MAX_CP);
			if (comp_bad) begin
				main_v   = 1'b1;
				main_cp  = inv_cp;
				main_bad = 1'b1;
			end else if (!(!header_seen_q && drop_leading_bom && (cv == BOM_CP))) begin
				main_v  = 1'b1;
				main_cp = cv;
			end
		end

		// A sequence still open at the end of the stream is replaced.
		tail = flush && (pend_n != 2'd0);
		if (tail) begin
			pend_n = 2'd0;
			len_n  = 2'd0;
			part_n = '0;
		end

		n_res    = {1'b0, broken} + {1'b0, main_v} + {1'b0, tail};
		ev_valid = accept && (n_res != 2'd0);
		ev.two   = (n_res == 2'd2);
		if (broken) begin
			ev.cp0  = inv_cp;
			ev.bad0 = 1'b1;
		end else if (main_v) begin
			ev.cp0  = main_cp;
			ev.bad0 = main_bad;
		end else begin
			ev.cp0  = inv_cp;
			ev.bad0 = 1'b1;
		end
		if (broken && main_v) begin
			ev.cp1  = main_cp;
			ev.bad1 = main_bad;
		end else begin
			ev.cp1  = inv_cp;
			ev.bad1 = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= 2'd0;
			seq_len_q     <= 2'd0;
			partial_q     <= '0;
			header_seen_q <= 1'b0;
		end else if (accept) begin
			pending_q     <= pend_n;
			seq_len_q     <= len_n;
			partial_q     <= part_n;
			header_seen_q <= hdr_n;
		end
	end

endmodule

### rtl/u8d_evq.sv
`timescale 1ns / 1ps
// Short queue of decoded events between the front and back ends.
// Uses u8d_pkg for the event type.
module u8d_evq
	import u8d_pkg::*;
#(
	parameter int DEPTH = EVQ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  u8d_event_t wr_data,
	input  logic       rd_en,
	output u8d_event_t rd_data,
	output logic       full,
	output logic       not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	u8d_event_t     mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/u8d_back.sv
`timescale 1ns / 1ps
// Back end of the UTF-8 decoder: expands each event into results, keeps the
// saturating replacement count and holds the output register. Uses u8d_pkg.
module u8d_back
	import u8d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ev_avail,
	input  u8d_event_t         ev,
	output logic               ev_take,
	input  logic               pop,
	output logic               empty,
	output logic [CP_W-1:0]    code_point,
	output logic               is_invalid,
	output logic [TOTAL_W-1:0] invalid_total,
	output logic               last
);

	logic               slot_q;
	logic               out_valid_q;
	logic [CP_W-1:0]    cp_q;
	logic               bad_q;
	logic [TOTAL_W-1:0] total_q;
	logic               last_q;
	logic [TOTAL_W-1:0] count_q;

	logic               load;
	logic [CP_W-1:0]    sel_cp;
	logic               sel_bad;
	logic               sel_last;
	logic [TOTAL_W-1:0] count_n;

	always_comb begin
		load     = ev_avail && (!out_valid_q || pop);
		sel_cp   = slot_q ? ev.cp1 : ev.cp0;
		sel_bad  = slot_q ? ev.bad1 : ev.bad0;
		sel_last = slot_q || !ev.two;
		count_n  = (sel_bad && (count_q != TOTAL_MAX)) ? count_q + TOTAL_W'(1) : count_q;
		ev_take  = load && sel_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (load) begin
				slot_q      <= !sel_last;
				out_valid_q <= 1'b1;
				count_q     <= count_n;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q    <= sel_cp;
			bad_q   <= sel_bad;
			total_q <= count_n;
			last_q  <= sel_last;
		end
	end

	assign empty         = !out_valid_q;
	assign code_point    = cp_q;
	assign is_invalid    = bad_q;
	assign invalid_total = total_q;
	assign last          = last_q;

endmodule

### rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// UTF-8 stream decoder: takes one byte per transaction and gives one code point
// per completed sequence, with U+FFFD (or U+0000 when invalid_as_null is set) for
// each malformed case, a saturating count of replacements, and a dropped leading
// BOM when drop_leading_bom is set. A byte is accepted every cycle while the event
// queue (DEPTH entries) has room; results leave the output register at one per
// cycle while pop is given, so a byte that causes two results holds the back end
// longer and the queue absorbs the difference. The event of an accepted byte is
// written to the queue; its result reaches the output ports when the back end loads
// it into the output register. Uses u8d_pkg, u8d_front, u8d_evq and u8d_back.
module utf8_stream_decoder
	import u8d_pkg::*;
#(
	parameter int DEPTH = EVQ_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            byte_value,
	input  logic                  flush,
	output logic                  empty,
	input  logic                  pop,
	output logic [CP_W-1:0]       code_point,
	output logic                  is_invalid,
	output logic [TOTAL_W-1:0]    invalid_total,
	output logic                  last
);

	logic       invalid_as_null_q;
	logic       drop_leading_bom_q;
	logic       accept;
	logic       evq_push;
	u8d_event_t evq_wdata;
	u8d_event_t evq_rdata;
	logic       evq_full;
	logic       evq_avail;
	logic       evq_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invalid_as_null_q  <= 1'b0;
			drop_leading_bom_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INVALID_AS_NULL:  invalid_as_null_q  <= cfg_data[0];
				REG_DROP_LEADING_BOM: drop_leading_bom_q <= cfg_data[0];
				default:              ;
			endcase
		end
	end

	assign full   = evq_full;
	assign accept = push && !evq_full;

	u8d_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.byte_value       (byte_value),
		.flush            (flush),
		.invalid_as_null  (invalid_as_null_q),
		.drop_leading_bom (drop_leading_bom_q),
		.ev_valid         (evq_push),
		.ev               (evq_wdata)
	);

	u8d_evq #(
		.DEPTH (DEPTH)
	) u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (evq_push),
		.wr_data   (evq_wdata),
		.rd_en     (evq_pop),
		.rd_data   (evq_rdata),
		.full      (evq_full),
		.not_empty (evq_avail)
	);

	u8d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev_avail      (evq_avail),
		.ev            (evq_rdata),
		.ev_take       (evq_pop),
		.pop           (pop),
		.empty         (empty),
		.code_point    (code_point),
		.is_invalid    (is_invalid),
		.invalid_total (invalid_total),
		.last          (last)
	);

`ifndef SYNTHESIS
	// Each replacement that follows a taken result counts exactly one more, unless the count has saturated.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) ##1 (!empty && is_invalid) |->
			(invalid_total == $past(invalid_total) + TOTAL_W'(1)) ||
			($past(invalid_total) == TOTAL_MAX))
		else $error("replacement count did not advance by one");

	// A result that is not a replacement is a Unicode scalar value.
	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_invalid) |->
			(code_point <= MAX_CP) && !((code_point >= SURR_LO) && (code_point <= SURR_HI)))
		else $error("valid result is not a scalar value");

	// The front end only produces events for accepted bytes.
	a_evq_push: assert property (@(posedge clk) disable iff (!arst_n)
		evq_push |-> (push && !evq_full))
		else $error("event written without an accepted byte");
`endif

endmodule
